[hdl/lcd_nibble_write_queue_top_assert.svh]
`ifndef LCD_NIBBLE_WRITE_QUEUE_TOP_ASSERT_SVH
`define LCD_NIBBLE_WRITE_QUEUE_TOP_ASSERT_SVH

// Both macros sample on the rising clock and are quiet while reset is high.
`define LNWQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define LNWQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lnwq_pkg.sv]
package lnwq_pkg;

   typedef logic [7:0] char_type;
   typedef logic [6:0] word_type;
   typedef logic [2:0] step_type;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam int CMD_MARK_IDX = 7;
   localparam int EN_IDX = 6;
   localparam word_type EN_BIT = 7'h40;
   localparam word_type END_WORD = 7'h00;

   localparam step_type STEP_HI_SETUP = 3'd0;
   localparam step_type STEP_HI_PULSE = 3'd1;
   localparam step_type STEP_HI_HOLD = 3'd2;
   localparam step_type STEP_LO_SETUP = 3'd3;
   localparam step_type STEP_LO_PULSE = 3'd4;
   localparam step_type STEP_LO_HOLD = 3'd5;
   localparam step_type STEP_END = 3'd6;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ser_status_type;

endpackage

[hdl/lnwq_channels.sv]
interface lnwq_req_if import lnwq_pkg::*; ();
   logic valid;
   logic ready;
   logic command;
   char_type byte_in;

   modport source(output valid, output command, output byte_in, input ready);
   modport sink(input valid, input command, input byte_in, output ready);
endinterface

interface lnwq_rsp_if import lnwq_pkg::*; ();
   logic valid;
   logic ready;
   word_type port_word;
   logic last;

   modport source(output valid, output port_word, output last, input ready);
   modport sink(input valid, input port_word, input last, output ready);
endinterface

[hdl/lnwq_cell.sv]
module lnwq_cell import lnwq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  char_type      new_data,
   input  char_type      neighbor_data,
   output char_type      held_data
);

   char_type data_ff;
   char_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.write) begin
         data_in = new_data;
      end else if (ctrl.shift) begin
         data_in = neighbor_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_data = data_ff;

endmodule

[hdl/lnwq_serializer.sv]
module lnwq_serializer import lnwq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  char_type       load_data,
   output ser_status_type status,
   lnwq_rsp_if.source     rsp_ch
);

   logic     busy_ff;
   logic     busy_in;
   step_type step_ff;
   step_type step_in;
   char_type char_ff;
   char_type char_in;
   logic     beat;
   logic     rs;
   word_type hi_word;
   word_type lo_word;

   assign beat = busy_ff && rsp_ch.ready;
   assign rs = !char_ff[CMD_MARK_IDX];
   assign hi_word = {2'b00, rs, char_ff[7:4]};
   assign lo_word = {2'b00, rs, char_ff[3:0]};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      char_in = char_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = STEP_HI_SETUP;
         char_in = load_data;
      end else if (beat) begin
         if (step_ff == STEP_END) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_HI_SETUP;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      char_ff <= char_in;
   end

   always_comb begin
      case (step_ff)
         STEP_HI_SETUP: rsp_ch.port_word = hi_word;
         STEP_HI_PULSE: rsp_ch.port_word = hi_word | EN_BIT;
         STEP_HI_HOLD:  rsp_ch.port_word = hi_word;
         STEP_LO_SETUP: rsp_ch.port_word = lo_word;
         STEP_LO_PULSE: rsp_ch.port_word = lo_word | EN_BIT;
         STEP_LO_HOLD:  rsp_ch.port_word = lo_word;
         default:       rsp_ch.port_word = END_WORD;
      endcase
   end

   assign rsp_ch.valid = busy_ff;
   assign rsp_ch.last = (step_ff == STEP_END);
   assign status.busy = busy_ff;
   assign status.done = beat && (step_ff == STEP_END);

endmodule

[hdl/lcd_nibble_write_queue_top.sv]
// Byte queue in front of a character display driven over a 4-bit bus.
// The req_ch channel takes beats with command and byte_in: an enqueue beat stores
// byte_in (dropped when the queue is full) and gives no result; a dequeue beat on
// a non-empty queue removes the oldest byte and sends seven beats on rsp_ch:
// high nibble setup, enable pulse, hold, the same for the low nibble, then a zero
// word with last set. A dequeue on an empty queue gives nothing.
// Storage is a row of QUEUE_DEPTH byte cells; a dequeue shifts every cell toward
// the head, and an enqueue writes the cell just past the stored bytes.
// After a dequeue beat the first rsp_ch word appears in the next cycle, and
// req_ch is ready again only in the cycle of the final beat, so no enqueue or
// dequeue is taken while the output serializer is still sending a byte.
// While rsp_ch stalls, the current word holds and req_ch is not ready.
// Reset (synchronous, active high) empties the queue.
module lcd_nibble_write_queue_top import lnwq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   lnwq_req_if.sink   req_ch,
   lnwq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             req_beat;
   logic             enq;
   logic             deq;
   logic             full;
   ser_status_type   ser_status;
   char_type         cell_data [QUEUE_DEPTH];

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign req_ch.ready = !ser_status.busy || ser_status.done;
   assign req_beat = req_ch.valid && req_ch.ready;
   assign enq = req_beat && (req_ch.command == CMD_ENQUEUE) && !full;
   assign deq = req_beat && (req_ch.command == CMD_DEQUEUE) && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      char_type      neighbor;

      assign ctrl.shift = deq;
      assign ctrl.write = enq && (count_ff == CNT_W'(i));

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign neighbor = req_ch.byte_in;
      end else begin : g_mid
         assign neighbor = cell_data[i+1];
      end

      lnwq_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .new_data      (req_ch.byte_in),
         .neighbor_data (neighbor),
         .held_data     (cell_data[i])
      );
   end

   lnwq_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (deq),
      .load_data (cell_data[0]),
      .status    (ser_status),
      .rsp_ch    (rsp_ch)
   );

endmodule

[hdl/lnwq_checker.sv]
`include "lcd_nibble_write_queue_top_assert.svh"

module lnwq_checker import lnwq_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input word_type rsp_port_word,
   input logic     rsp_last
);

   `LNWQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat withdrawn")
   `LNWQ_ASSERT_SAME(a_last_zero, rsp_valid && rsp_last, rsp_port_word == END_WORD, "last word not zero")
   `LNWQ_ASSERT_NEXT(a_pulse_hold, rsp_valid && rsp_ready && rsp_port_word[EN_IDX], rsp_valid && !rsp_last && !rsp_port_word[EN_IDX] && (rsp_port_word[5:0] == $past(rsp_port_word[5:0])), "enable pulse not followed by hold word")
   `LNWQ_ASSERT_SAME(a_busy_block, rsp_valid && !(rsp_ready && rsp_last), !req_ready, "request taken during a byte")

endmodule

bind lcd_nibble_write_queue_top lnwq_checker u_lnwq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_port_word (rsp_ch.port_word),
   .rsp_last      (rsp_ch.last)
);
